### src/rcm_pkg.sv
// Shared types, wiring tables and mod-26 helpers for the rotor cipher machine.
// No dependencies; imported by rcm_plugboard, rotor_cipher_machine and the testbench.
package rcm_pkg;

  localparam int PLUG_PAIRS   = 10;
  localparam int PAIR_SLOTS   = 10;
  localparam int ACTIVE_PAIRS = (PLUG_PAIRS < PAIR_SLOTS) ? PLUG_PAIRS : PAIR_SLOTS;
  localparam int LETTERS      = 26;
  localparam int ROTORS       = 5;

  localparam logic [2:0] REG_ROTOR_ORDER     = 3'd0;
  localparam logic [2:0] REG_RING_OFFSETS    = 3'd1;
  localparam logic [2:0] REG_START_POSITIONS = 3'd2;
  localparam logic [2:0] REG_PLUG_LOW        = 3'd3;
  localparam logic [2:0] REG_PLUG_HIGH       = 3'd4;

  localparam logic [8:0] ROTOR_ORDER_RESET = 9'd10;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] rotor_sel_t;
  typedef logic [LETTERS-1:0][4:0] plug_map_t;

  typedef struct packed {
    letter_t left;
    letter_t middle;
    letter_t right;
  } rotor_pos_t;

  localparam letter_t WIRING [ROTORS][LETTERS] = '{
    '{5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19, 5'd14,
      5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9},
    '{5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7, 5'd22,
      5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4},
    '{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25,
      5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14},
    '{5'd4, 5'd18, 5'd14, 5'd21, 5'd15, 5'd25, 5'd9, 5'd0, 5'd24, 5'd16, 5'd20, 5'd8, 5'd17,
      5'd7, 5'd23, 5'd11, 5'd13, 5'd6, 5'd10, 5'd3, 5'd2, 5'd12, 5'd19, 5'd22, 5'd1, 5'd5},
    '{5'd21, 5'd25, 5'd1, 5'd17, 5'd6, 5'd8, 5'd19, 5'd24, 5'd20, 5'd15, 5'd18, 5'd3, 5'd13,
      5'd7, 5'd11, 5'd23, 5'd0, 5'd22, 5'd12, 5'd5, 5'd2, 5'd16, 5'd14, 5'd4, 5'd10, 5'd9}
  };

  localparam letter_t REFLECTOR_B [LETTERS] = '{
    5'd24, 5'd17, 5'd20, 5'd7, 5'd16, 5'd18, 5'd11, 5'd3, 5'd15, 5'd23, 5'd13, 5'd6, 5'd14,
    5'd10, 5'd12, 5'd8, 5'd4, 5'd1, 5'd5, 5'd25, 5'd2, 5'd22, 5'd21, 5'd9, 5'd0, 5'd19
  };

  localparam letter_t NOTCH_AT [ROTORS] = '{5'd16, 5'd4, 5'd21, 5'd9, 5'd25};

  function automatic letter_t wrap26(input letter_t v);
    return (v >= 5'd26) ? 5'(v - 5'd26) : v;
  endfunction

  function automatic rotor_sel_t pick_rotor(input logic [2:0] v);
    return (v > 3'd4) ? 3'd4 : v;
  endfunction

  function automatic letter_t add26(input letter_t a, input letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 6'd26) ? 5'(s - 6'd26) : s[4:0];
  endfunction

  function automatic letter_t sub26(input letter_t a, input letter_t b);
    return (a >= b) ? 5'(a - b) : 5'(a + 5'd26 - b);
  endfunction

  function automatic letter_t rotor_fwd(input letter_t c, input rotor_sel_t r,
                                        input letter_t sh);
    return sub26(WIRING[r][add26(c, sh)], sh);
  endfunction

  function automatic letter_t rotor_bwd(input letter_t c, input rotor_sel_t r,
                                        input letter_t sh);
    letter_t i;
    letter_t j;
    i = add26(c, sh);
    j = 5'd25;
    for (int k = LETTERS - 1; k >= 0; k--) begin
      if (WIRING[r][k] == i) begin
        j = 5'(k);
      end
    end
    return sub26(j, sh);
  endfunction

endpackage

### src/rcm_plugboard.sv
// Plugboard swap map, rebuilt each cycle from the two pair registers.
// Depends on rcm_pkg.
module rcm_plugboard import rcm_pkg::*; (
  input  logic        clk,
  input  logic [49:0] plug_pairs_low,
  input  logic [49:0] plug_pairs_high,
  output plug_map_t   swap_map
);

  plug_map_t           swap_map_next;
  logic [LETTERS-1:0]  used;
  logic [99:0]         pairs;
  letter_t             a;
  letter_t             b;

  assign pairs = {plug_pairs_high, plug_pairs_low};

  always_comb begin
    used = '0;
    a = '0;
    b = '0;
    for (int k = 0; k < LETTERS; k++) begin
      swap_map_next[k] = 5'(k);
    end
    for (int k = 0; k < ACTIVE_PAIRS; k++) begin
      a = pairs[10*k +: 5];
      b = pairs[10*k + 5 +: 5];
      if (a < 5'd26 && b < 5'd26 && a != b) begin
        if (!used[a] && !used[b]) begin
          swap_map_next[a] = b;
          swap_map_next[b] = a;
          used[a] = 1'b1;
          used[b] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    swap_map <= swap_map_next;
  end

endmodule

### src/rotor_cipher_machine.sv
// Three-rotor machine with reflector B: stepping, plugboard and rotor path.
// Throughput 1 letter per cycle while the output is not stalled (s_tready drops when m_tvalid && !m_tready).
// Four register stages (step, forward, reflect, backward) advance together.
// Reset: synchronous; clears stage valids, rotor positions to 0, config to reset values.
// Depends on rcm_pkg and rcm_plugboard.
module rotor_cipher_machine import rcm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] letter, [7:5] zero
  input  logic        s_tuser,   // [0] message_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [4:0] cipher_letter, [9:5] left_window,
                                 // [14:10] middle_window, [19:15] right_window, [23:20] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [49:0] cfg_data
);

  logic [8:0]  rotor_order;
  logic [14:0] ring_offsets;
  logic [14:0] start_positions;
  logic [49:0] plug_pairs_low;
  logic [49:0] plug_pairs_high;

  plug_map_t   swap_map;

  rotor_pos_t  position;
  rotor_pos_t  position_next;
  rotor_pos_t  cur;

  rotor_sel_t  rl, rm, rr;
  letter_t     gl, gm, gr;
  logic        advance, accept;
  logic        mid_notch, right_notch;

  logic        v1, v2, v3;
  letter_t     s1_letter;
  rotor_pos_t  s1_win, s2_win, s3_win;
  letter_t     s1_sh_l, s1_sh_m, s1_sh_r;
  letter_t     s2_sh_l, s2_sh_m, s2_sh_r;
  letter_t     s3_sh_m, s3_sh_r;
  letter_t     c2, c3;
  letter_t     c2_next, c3_next, cipher_next;
  letter_t     cipher;
  rotor_pos_t  out_win;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotor_order     <= ROTOR_ORDER_RESET;
      ring_offsets    <= '0;
      start_positions <= '0;
      plug_pairs_low  <= '0;
      plug_pairs_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROTOR_ORDER:     rotor_order     <= cfg_data[8:0];
        REG_RING_OFFSETS:    ring_offsets    <= cfg_data[14:0];
        REG_START_POSITIONS: start_positions <= cfg_data[14:0];
        REG_PLUG_LOW:        plug_pairs_low  <= cfg_data;
        REG_PLUG_HIGH:       plug_pairs_high <= cfg_data;
        default: ;
      endcase
    end
  end

  rcm_plugboard u_plugboard (
    .clk             (clk),
    .plug_pairs_low  (plug_pairs_low),
    .plug_pairs_high (plug_pairs_high),
    .swap_map        (swap_map)
  );

  assign rl = pick_rotor(rotor_order[8:6]);
  assign rm = pick_rotor(rotor_order[5:3]);
  assign rr = pick_rotor(rotor_order[2:0]);
  assign gl = wrap26(ring_offsets[14:10]);
  assign gm = wrap26(ring_offsets[9:5]);
  assign gr = wrap26(ring_offsets[4:0]);

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && s_tready;

  // on message_start load the start positions, then step rotors odometer-style with the middle-rotor double step
  always_comb begin
    if (s_tuser) begin
      cur.left   = wrap26(start_positions[14:10]);
      cur.middle = wrap26(start_positions[9:5]);
      cur.right  = wrap26(start_positions[4:0]);
    end else begin
      cur = position;
    end
    mid_notch   = cur.middle == NOTCH_AT[rm];
    right_notch = cur.right == NOTCH_AT[rr];
    position_next.left   = mid_notch ? add26(cur.left, 5'd1) : cur.left;
    position_next.middle = (mid_notch || right_notch) ? add26(cur.middle, 5'd1) : cur.middle;
    position_next.right  = add26(cur.right, 5'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept) begin
      position <= position_next;
    end
  end

  assign c2_next = rotor_fwd(rotor_fwd(swap_map[s1_letter], rr, s1_sh_r), rm, s1_sh_m);
  assign c3_next = rotor_bwd(REFLECTOR_B[rotor_fwd(c2, rl, s2_sh_l)], rl, s2_sh_l);
  assign cipher_next = swap_map[rotor_bwd(rotor_bwd(c3, rm, s3_sh_m), rr, s3_sh_r)];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      v1       <= accept;
      v2       <= v1;
      v3       <= v2;
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_letter <= wrap26(s_tdata[4:0]);
      s1_win    <= position_next;
      s1_sh_l   <= sub26(position_next.left, gl);
      s1_sh_m   <= sub26(position_next.middle, gm);
      s1_sh_r   <= sub26(position_next.right, gr);

      c2        <= c2_next;
      s2_win    <= s1_win;
      s2_sh_l   <= s1_sh_l;
      s2_sh_m   <= s1_sh_m;
      s2_sh_r   <= s1_sh_r;

      c3        <= c3_next;
      s3_win    <= s2_win;
      s3_sh_m   <= s2_sh_m;
      s3_sh_r   <= s2_sh_r;

      cipher    <= cipher_next;
      out_win   <= s3_win;
    end
  end

  assign m_tdata = {4'd0, out_win.right, out_win.middle, out_win.left, cipher};

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (cipher < 5'd26) && (out_win.left < 5'd26) &&
                 (out_win.middle < 5'd26) && (out_win.right < 5'd26))
    else $error("result letter or window out of range");

  a_left_needs_middle: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tuser) |=> (position.left == $past(position.left)) ||
                             (position.middle != $past(position.middle)))
    else $error("left rotor stepped without the middle rotor");

  a_right_steps: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tuser) |=> position.right != $past(position.right))
    else $error("right rotor failed to step");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !v1 && !v2 && !v3)
    else $error("pipeline not empty after reset");

endmodule

### tb/testbench.sv
// Testbench for rotor_cipher_machine: directed and random letter streams checked beat by beat
// against a predictor of the three-rotor machine kept in this file.
// Depends on rcm_pkg (register indexes, letter type) and the rotor_cipher_machine RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_LETTERS  = 120;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} traffic_mode_t;

  // cipher letter in the low bits, as on m_tdata
  typedef struct packed {
    letter_t right;
    letter_t middle;
    letter_t left;
    letter_t cipher;
  } cipher_beat_t;

  localparam int rotor_map [5][26] = '{
    '{4, 10, 12, 5, 11, 6, 3, 16, 21, 25, 13, 19, 14, 22, 24, 7, 23, 20, 18, 15, 0, 8, 1,
      17, 2, 9},
    '{0, 9, 3, 10, 18, 8, 17, 20, 23, 1, 11, 7, 22, 19, 12, 2, 16, 6, 25, 13, 15, 24, 5,
      21, 14, 4},
    '{1, 3, 5, 7, 9, 11, 2, 15, 17, 19, 23, 21, 25, 13, 24, 4, 8, 22, 6, 0, 10, 12, 20,
      18, 16, 14},
    '{4, 18, 14, 21, 15, 25, 9, 0, 24, 16, 20, 8, 17, 7, 23, 11, 13, 6, 10, 3, 2, 12, 19,
      22, 1, 5},
    '{21, 25, 1, 17, 6, 8, 19, 24, 20, 15, 18, 3, 13, 7, 11, 23, 0, 22, 12, 5, 2, 16, 14,
      4, 10, 9}
  };
  localparam int reflect_map [26] = '{24, 17, 20, 7, 16, 18, 11, 3, 15, 23, 13, 6, 14, 10,
                                      12, 8, 4, 1, 5, 25, 2, 22, 21, 9, 0, 19};
  localparam int notch_pos [5] = '{16, 4, 21, 9, 25};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [4:0] letter, [7:5] zero
  logic        s_tuser = 1'b0; // [0] message_start
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [23:0] m_tdata;        // [4:0] cipher, [9:5] left, [14:10] middle, [19:15] right
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [49:0] cfg_data = '0;

  logic [8:0]  order_q = ROTOR_ORDER_RESET;
  logic [14:0] ring_q = '0;
  logic [14:0] start_q = '0;
  logic [49:0] plug_lo_q = '0;
  logic [49:0] plug_hi_q = '0;
  int pos_left = 0;
  int pos_mid = 0;
  int pos_right = 0;

  cipher_beat_t pending_beats[$];
  int error_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  rotor_cipher_machine dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int wrap_letter(logic [4:0] v);
    int x;
    x = v;
    return (x >= 26) ? x - 26 : x;
  endfunction

  function automatic int rotor_pick(logic [2:0] v);
    return (v > 3'd4) ? 4 : int'(v);
  endfunction

  function automatic int rotor_pass(int c, int r, int sh, bit inverse);
    int i;
    int j;
    i = (c + sh) % 26;
    if (!inverse) begin
      return (rotor_map[r][i] + 26 - sh) % 26;
    end
    j = 0;
    while (j < 25 && rotor_map[r][j] != i) j++;
    return (j + 26 - sh) % 26;
  endfunction

  function automatic cipher_beat_t machine_step(logic [4:0] ltr, logic restart);
    int plug [26];
    bit taken [26];
    int rl, rm, rr, sl, sm, sr, a, b, c;
    bit mid_notch, right_notch;
    logic [49:0] pairs;
    cipher_beat_t res;
    rl = rotor_pick(order_q[8:6]);
    rm = rotor_pick(order_q[5:3]);
    rr = rotor_pick(order_q[2:0]);
    if (restart) begin
      pos_left = wrap_letter(start_q[14:10]);
      pos_mid = wrap_letter(start_q[9:5]);
      pos_right = wrap_letter(start_q[4:0]);
    end
    mid_notch = pos_mid == notch_pos[rm];
    right_notch = pos_right == notch_pos[rr];
    if (mid_notch) pos_left = (pos_left + 1) % 26;
    if (mid_notch || right_notch) pos_mid = (pos_mid + 1) % 26;
    pos_right = (pos_right + 1) % 26;
    for (int k = 0; k < 26; k++) begin
      plug[k] = k;
      taken[k] = 1'b0;
    end
    for (int k = 0; k < PLUG_PAIRS && k < 10; k++) begin
      pairs = (k < 5) ? plug_lo_q : plug_hi_q;
      a = pairs[10 * (k % 5) +: 5];
      b = pairs[10 * (k % 5) + 5 +: 5];
      if (a < 26 && b < 26 && a != b && !taken[a] && !taken[b]) begin
        plug[a] = b;
        plug[b] = a;
        taken[a] = 1'b1;
        taken[b] = 1'b1;
      end
    end
    sl = (pos_left + 26 - wrap_letter(ring_q[14:10])) % 26;
    sm = (pos_mid + 26 - wrap_letter(ring_q[9:5])) % 26;
    sr = (pos_right + 26 - wrap_letter(ring_q[4:0])) % 26;
    c = plug[wrap_letter(ltr)];
    c = rotor_pass(c, rr, sr, 1'b0);
    c = rotor_pass(c, rm, sm, 1'b0);
    c = rotor_pass(c, rl, sl, 1'b0);
    c = reflect_map[c];
    c = rotor_pass(c, rl, sl, 1'b1);
    c = rotor_pass(c, rm, sm, 1'b1);
    c = rotor_pass(c, rr, sr, 1'b1);
    c = plug[c % 26];
    res.cipher = 5'(c);
    res.left = 5'(pos_left);
    res.middle = 5'(pos_mid);
    res.right = 5'(pos_right);
    return res;
  endfunction

  function automatic logic [49:0] pos3(int l, int m, int r);
    return 50'({5'(l), 5'(m), 5'(r)});
  endfunction

  function automatic logic [4:0] rand_letter(int raw_pct);
    return ($urandom_range(99) < raw_pct) ? 5'($urandom_range(31)) : 5'($urandom_range(25));
  endfunction

  function automatic logic [2:0] rand_rotor();
    return ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
  endfunction

  function automatic logic [49:0] rand_plugs();
    logic [49:0] p;
    if ($urandom_range(3) == 0) begin
      p = 50'({$urandom, $urandom});
    end else begin
      for (int k = 0; k < 5; k++) p[10 * k +: 10] = {rand_letter(10), rand_letter(10)};
    end
    return p;
  endfunction

  function automatic void check_field(string name, letter_t want_v, letter_t got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      error_count++;
    end
  endfunction

  always @(negedge clk) begin
    m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cipher_beat_t want;
    cipher_beat_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = cipher_beat_t'(m_tdata[19:0]);
      if (pending_beats.size() == 0) begin
        $error("result beat with no letter outstanding: %h", m_tdata);
        error_count++;
      end else begin
        want = pending_beats.pop_front();
        check_field("cipher_letter", want.cipher, got.cipher);
        check_field("left_window", want.left, got.left);
        check_field("middle_window", want.middle, got.middle);
        check_field("right_window", want.right, got.right);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("rotor_cipher_machine: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_letter(input logic [4:0] ltr, input logic restart);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, ltr};
    s_tuser <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_beats.push_back(machine_step(ltr, restart));
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [49:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ROTOR_ORDER:     order_q = value[8:0];
      REG_RING_OFFSETS:    ring_q = value[14:0];
      REG_START_POSITIONS: start_q = value[14:0];
      REG_PLUG_LOW:        plug_lo_q = value;
      REG_PLUG_HIGH:       plug_hi_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    send_letter(5'd0, 1'b1);
    send_letter(5'd0, 1'b0);
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd31, 1'b0);
    send_letter(5'd26, 1'b0);
    settle();
  endtask

  task automatic test_double_step();
    write_reg(REG_START_POSITIONS, pos3(0, 3, 20));
    send_letter(5'd0, 1'b1);
    send_letter(5'd1, 1'b0);
    send_letter(5'd2, 1'b0);
    send_letter(5'd3, 1'b0);
    settle();
  endtask

  task automatic test_rotor_choices();
    write_reg(REG_ROTOR_ORDER, 50'h1FF);
    write_reg(REG_START_POSITIONS, pos3(0, 25, 25));
    send_letter(5'd7, 1'b1);
    send_letter(5'd8, 1'b0);
    settle();
    write_reg(REG_ROTOR_ORDER, 50'({3'd5, 3'd6, 3'd3}));
    write_reg(REG_START_POSITIONS, pos3(0, 24, 9));
    send_letter(5'd4, 1'b1);
    send_letter(5'd20, 1'b0);
    settle();
  endtask

  task automatic test_ring_and_wrap();
    write_reg(REG_RING_OFFSETS, 50'h7FFF);
    write_reg(REG_START_POSITIONS, 50'h7FFF);
    send_letter(5'd31, 1'b1);
    send_letter(5'd17, 1'b0);
    settle();
    write_reg(REG_RING_OFFSETS, pos3(25, 25, 25));
    write_reg(REG_START_POSITIONS, pos3(25, 25, 25));
    send_letter(5'd25, 1'b1);
    send_letter(5'd0, 1'b0);
    settle();
  endtask

  task automatic test_plugboard();
    write_reg(REG_ROTOR_ORDER, 50'(ROTOR_ORDER_RESET));
    write_reg(REG_PLUG_LOW, {5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1, 5'd0});
    // a good pair, overlap with an earlier pair, equal letters, out-of-range letter, another good pair
    write_reg(REG_PLUG_HIGH, {5'd25, 5'd24, 5'd14, 5'd30, 5'd13, 5'd13, 5'd12, 5'd0,
                              5'd11, 5'd10});
    send_letter(5'd0, 1'b1);
    send_letter(5'd12, 1'b0);
    send_letter(5'd13, 1'b0);
    send_letter(5'd14, 1'b0);
    send_letter(5'd25, 1'b0);
    settle();
  endtask

  task automatic test_ignored_writes();
    for (int i = REG_PLUG_HIGH + 1; i < 8; i++) write_reg(3'(i), '1);
    write_reg(REG_PLUG_LOW, '1);
    write_reg(REG_PLUG_HIGH, '1);
    send_letter(5'd5, 1'b1);
    send_letter(5'd19, 1'b0);
    settle();
  endtask

  task automatic test_random_traffic();
    traffic_mode_t mode;
    logic [8:0] order;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = traffic_mode_t'(phase % 4);
      case (mode)
        IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        IDLE_SENDER:   begin send_idle_pct = 82; recv_stall_pct = 0;  end
        IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        IDLE_BOTH:     begin send_idle_pct = 7;  recv_stall_pct = 7;  end
      endcase
      if (phase == 0) begin
        write_reg(REG_ROTOR_ORDER, '0);
        write_reg(REG_RING_OFFSETS, '0);
        write_reg(REG_START_POSITIONS, '0);
        write_reg(REG_PLUG_LOW, '0);
        write_reg(REG_PLUG_HIGH, '0);
      end else if (phase == 1) begin
        write_reg(REG_ROTOR_ORDER, 50'h1FF);
        write_reg(REG_RING_OFFSETS, 50'h7FFF);
        write_reg(REG_START_POSITIONS, 50'h7FFF);
        write_reg(REG_PLUG_LOW, '1);
        write_reg(REG_PLUG_HIGH, '1);
      end else begin
        order = {rand_rotor(), rand_rotor(), rand_rotor()};
        write_reg(REG_ROTOR_ORDER, 50'(order));
        write_reg(REG_RING_OFFSETS, 50'({rand_letter(10), rand_letter(10), rand_letter(10)}));
        // park the middle rotor at or just short of its notch to provoke double steps
        if ($urandom_range(1) == 0) begin
          write_reg(REG_START_POSITIONS, pos3(rand_letter(10),
                    notch_pos[rotor_pick(order[5:3])] - $urandom_range(1), rand_letter(10)));
        end else begin
          write_reg(REG_START_POSITIONS,
                    50'({rand_letter(10), rand_letter(10), rand_letter(10)}));
        end
        write_reg(REG_PLUG_LOW, rand_plugs());
        write_reg(REG_PLUG_HIGH, rand_plugs());
      end
      for (int n = 0; n < PHASE_LETTERS; n++) begin
        send_letter(rand_letter(12), n == 0 || $urandom_range(29) == 0);
      end
      settle();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_double_step();
    test_rotor_choices();
    test_ring_and_wrap();
    test_plugboard();
    test_ignored_writes();
    test_random_traffic();
    if (error_count == 0) begin
      $display("rotor_cipher_machine: match");
    end else begin
      $display("rotor_cipher_machine: mismatch");
    end
    $finish;
  end

endmodule
